>>> rtl/ille_pkg.sv
// Shared types and constants for the indexed linked list engine.
// Depends on nothing; the engine, link memory, checker and testbench import it.
`timescale 1ns / 1ps
`default_nettype none

package ille_pkg;

    // Store geometry.
    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Request opcodes.
    typedef enum logic [1:0] {
        OP_READ     = 2'd0,
        OP_INS_HEAD = 2'd1,
        OP_INS_TAIL = 2'd2,
        OP_REMOVE   = 2'd3
    } op_t;

    // Response status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        op_t                opcode;
        logic [15:0]        index;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] read_value;
        logic [6:0]         list_count;
    } rsp_t;

    // Write port of the link memory.
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        logic [SLOT_W-1:0] data;
    } link_wr_t;

endpackage

`default_nettype wire

>>> rtl/indexed_linked_list_engine.sv
// Top level of the indexed linked list engine: request sequencer and response register.
// Depends on ille_pkg, ille_ram (value store) and ille_link_mem (link store).
//
// Usage. Requests arrive on req (valid/ready) carrying an opcode, an index and a value:
// read at index, insert at head, insert at tail, or remove at index. Every accepted
// request produces exactly one response on rsp (valid/ready) with a status, the word
// read (minus one for a read with a bad index, zero otherwise) and the list length
// after the request.
// Pacing. Read and remove walk the links from the head, one link memory read per
// cycle, so the link memory read port sets the pace. An insert needs no walk, and a
// bad index or a full store is answered without touching the memories; the slowest
// request is a remove of the last entry of a full list. One request is worked on at a
// time; the next request can be taken in the cycle in which the response appears.
// Reset. The list is empty, and the free chain covers every slot in order, held in
// the link memory by per-entry valid bits rather than a clearing pass, so requests
// are accepted as soon as reset is released.
// Stalls. The response sits in an output register. A new request is accepted while
// an earlier response still waits; its own response waits in the sequencer until
// the output register is free, and no request is accepted meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module indexed_linked_list_engine (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    input  wire ille_pkg::req_t req,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    output ille_pkg::rsp_t      rsp
);

    import ille_pkg::*;

    // Sequencer states, one-hot.
    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_WALK  = 8'b0000_0010,
        S_VWAIT = 8'b0000_0100,
        S_RVICT = 8'b0000_1000,
        S_RNEXT = 8'b0001_0000,
        S_RFREE = 8'b0010_0000,
        S_INS   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t             state_reg,      state_next;
    op_t                op_reg,         op_next;
    logic [CNT_W-1:0]   idx_reg,        idx_next;
    logic [DATA_W-1:0]  val_reg,        val_next;
    logic [CNT_W-1:0]   rem_reg,        rem_next;
    logic [SLOT_W-1:0]  prev_reg,       prev_next;
    logic [SLOT_W-1:0]  work_slot_reg,  work_slot_next;
    logic [SLOT_W-1:0]  head_reg,       head_next;
    logic [SLOT_W-1:0]  tail_reg,       tail_next;
    logic [SLOT_W-1:0]  free_reg,       free_next;
    logic [CNT_W-1:0]   count_reg,      count_next;
    logic [1:0]         res_status_reg, res_status_next;
    logic signed [31:0] res_rd_reg,     res_rd_next;
    logic               rsp_valid_reg,  rsp_valid_next;
    rsp_t               rsp_reg,        rsp_next;

    // Memory ports.
    link_wr_t           link_wr;
    logic [SLOT_W-1:0]  link_raddr;
    logic [SLOT_W-1:0]  link_rdata;
    logic               val_we;
    logic [SLOT_W-1:0]  val_waddr;
    logic [DATA_W-1:0]  val_wdata;
    logic [SLOT_W-1:0]  val_raddr;
    logic [DATA_W-1:0]  val_rdata;

    logic               in_range;
    logic               accept;
    logic signed [DATA_W-1:0] stored_word;

    ille_link_mem u_link_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (link_wr),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    ille_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (DATA_W)
    ) u_value_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (val_wdata),
        .raddr (val_raddr),
        .rdata (val_rdata)
    );

    assign req_ready   = (state_reg == S_IDLE);
    assign accept      = req_valid && req_ready;
    assign in_range    = 32'(req.index) < 32'(count_reg);
    assign stored_word = val_rdata;
    assign rsp_valid   = rsp_valid_reg;
    assign rsp         = rsp_reg;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        idx_next        = idx_reg;
        val_next        = val_reg;
        rem_next        = rem_reg;
        prev_next       = prev_reg;
        work_slot_next  = work_slot_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        free_next       = free_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_rd_next     = res_rd_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_next        = rsp_reg;

        link_wr    = '0;
        link_raddr = head_reg;
        val_we     = 1'b0;
        val_waddr  = work_slot_reg;
        val_wdata  = val_reg;
        val_raddr  = head_reg;

        // The response register empties when the receiver takes it.
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next         = req.opcode;
                    idx_next        = CNT_W'(req.index);
                    val_next        = DATA_W'(req.value);
                    res_status_next = ST_OK;
                    res_rd_next     = '0;
                    unique case (req.opcode)
                        OP_READ:
                        begin
                            if (!in_range)
                            begin
                                res_status_next = ST_BAD_INDEX;
                                res_rd_next     = '1;
                                state_next      = S_DONE;
                            end
                            else if (req.index == 16'd0)
                            begin
                                val_raddr  = head_reg;
                                state_next = S_VWAIT;
                            end
                            else
                            begin
                                link_raddr = head_reg;
                                rem_next   = CNT_W'(req.index);
                                state_next = S_WALK;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (!in_range)
                            begin
                                res_status_next = ST_BAD_INDEX;
                                state_next      = S_DONE;
                            end
                            else if (req.index == 16'd0)
                            begin
                                work_slot_next = head_reg;
                                link_raddr     = head_reg;
                                state_next     = S_RNEXT;
                            end
                            else if (req.index == 16'd1)
                            begin
                                prev_next  = head_reg;
                                link_raddr = head_reg;
                                state_next = S_RVICT;
                            end
                            else
                            begin
                                link_raddr = head_reg;
                                rem_next   = CNT_W'(req.index) - CNT_W'(1);
                                state_next = S_WALK;
                            end
                        end
                        OP_INS_HEAD, OP_INS_TAIL:
                        begin
                            if (count_reg == CNT_W'(CAPACITY))
                            begin
                                res_status_next = ST_FULL;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                work_slot_next = free_reg;
                                link_raddr     = free_reg;
                                state_next     = S_INS;
                            end
                        end
                    endcase
                end
            end

            // One link followed per cycle; the returned link addresses the next read.
            S_WALK:
            begin
                if (rem_reg == CNT_W'(1))
                begin
                    if (op_reg == OP_READ)
                    begin
                        val_raddr  = link_rdata;
                        state_next = S_VWAIT;
                    end
                    else
                    begin
                        prev_next  = link_rdata;
                        link_raddr = link_rdata;
                        state_next = S_RVICT;
                    end
                end
                else
                begin
                    rem_next   = rem_reg - CNT_W'(1);
                    link_raddr = link_rdata;
                end
            end

            S_VWAIT:
            begin
                res_rd_next = 32'(stored_word);
                state_next  = S_DONE;
            end

            S_RVICT:
            begin
                work_slot_next = link_rdata;
                link_raddr     = link_rdata;
                state_next     = S_RNEXT;
            end

            // The victim's successor is known: unlink the victim.
            S_RNEXT:
            begin
                if (idx_reg == '0)
                begin
                    head_next = link_rdata;
                end
                else
                begin
                    link_wr.en   = 1'b1;
                    link_wr.addr = prev_reg;
                    link_wr.data = link_rdata;
                    if (idx_reg == count_reg - CNT_W'(1))
                    begin
                        tail_next = prev_reg;
                    end
                end
                state_next = S_RFREE;
            end

            // Return the victim to the front of the free chain.
            S_RFREE:
            begin
                link_wr.en   = 1'b1;
                link_wr.addr = work_slot_reg;
                link_wr.data = free_reg;
                free_next    = work_slot_reg;
                count_next   = count_reg - CNT_W'(1);
                if (count_reg == CNT_W'(1))
                begin
                    tail_next = '0;
                end
                state_next = S_DONE;
            end

            S_INS:
            begin
                free_next = link_rdata;
                val_we    = 1'b1;
                val_waddr = work_slot_reg;
                val_wdata = val_reg;
                if (op_reg == OP_INS_HEAD)
                begin
                    link_wr.en   = 1'b1;
                    link_wr.addr = work_slot_reg;
                    link_wr.data = head_reg;
                    head_next    = work_slot_reg;
                    if (count_reg == '0)
                    begin
                        tail_next = work_slot_reg;
                    end
                end
                else if (count_reg == '0)
                begin
                    head_next = work_slot_reg;
                    tail_next = work_slot_reg;
                end
                else
                begin
                    link_wr.en   = 1'b1;
                    link_wr.addr = tail_reg;
                    link_wr.data = work_slot_reg;
                    tail_next    = work_slot_reg;
                end
                count_next = count_reg + CNT_W'(1);
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next      = 1'b1;
                    rsp_next.status     = res_status_reg;
                    rsp_next.read_value = res_rd_reg;
                    rsp_next.list_count = 7'(count_reg);
                    state_next          = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            free_reg      <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            free_reg      <= free_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        idx_reg        <= idx_next;
        val_reg        <= val_next;
        rem_reg        <= rem_next;
        prev_reg       <= prev_next;
        work_slot_reg  <= work_slot_next;
        res_status_reg <= res_status_next;
        res_rd_reg     <= res_rd_next;
        rsp_reg        <= rsp_next;
    end

endmodule

`default_nettype wire

>>> rtl/ille_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing; used for the value store.
`timescale 1ns / 1ps
`default_nettype none

module ille_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> rtl/ille_link_mem.sv
// Link memory of the list: one write port, one registered read port.
// Depends on ille_pkg. Entries never written read back as the reset free chain.
`timescale 1ns / 1ps
`default_nettype none

module ille_link_mem (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire ille_pkg::link_wr_t       wr,
    input  wire logic [ille_pkg::SLOT_W-1:0] raddr,
    output logic      [ille_pkg::SLOT_W-1:0] rdata
);

    import ille_pkg::*;

    logic [SLOT_W-1:0]   mem [CAPACITY];
    logic [CAPACITY-1:0] valid_reg;
    logic [SLOT_W-1:0]   ram_q;
    logic [SLOT_W-1:0]   addr_q;
    logic                valid_q;
    logic [SLOT_W-1:0]   chain_next;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        ram_q  <= mem[raddr];
        addr_q <= raddr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            valid_q   <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            valid_q <= valid_reg[raddr];
        end
    end

    // Unwritten entries hold the reset free chain: slot i links slot i+1, wrapping.
    assign chain_next = (addr_q == SLOT_W'(CAPACITY - 1)) ? '0 : addr_q + SLOT_W'(1);
    assign rdata      = valid_q ? ram_q : chain_next;

endmodule

`default_nettype wire

>>> rtl/ille_checker.sv
// Port-level checks for the indexed linked list engine, bound to the top level.
// Depends on ille_pkg and on indexed_linked_list_engine.
`timescale 1ns / 1ps
`default_nettype none

module ille_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           req_valid,
    input wire logic           req_ready,
    input wire ille_pkg::req_t req,
    input wire logic           rsp_valid,
    input wire logic           rsp_ready,
    input wire ille_pkg::rsp_t rsp
);

    import ille_pkg::*;

    // A response held back by the receiver must not change.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

    // The list never reports more entries than the store holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> 32'(rsp.list_count) <= CAPACITY)
    else $error("list length beyond capacity");

    // A refused insert only happens with the store full.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_FULL |-> 32'(rsp.list_count) == CAPACITY)
    else $error("full status with free slots");

    // A bad index returns minus one for a read and zero for a remove; the check accepts either.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == ST_BAD_INDEX |->
            rsp.read_value == -32'sd1 || rsp.read_value == 32'sd0)
    else $error("bad index with unexpected word");

endmodule

bind indexed_linked_list_engine ille_checker u_ille_checker (.*);

`default_nettype wire

>>> test/tb.sv
// Self-checking testbench for the indexed linked list engine.
// Depends on ille_pkg and the engine RTL; the engine's behaviour is mirrored in a small class.
`timescale 1ns / 1ps

import ille_pkg::*;

// Mirror of the list held in the engine, with the queue of responses it is owed.
class list_scoreboard;
    typedef logic [SLOT_W-1:0] slot_t;

    logic signed [DATA_W-1:0] word_mem [CAPACITY];
    slot_t                    next_mem [CAPACITY];
    slot_t                    head;
    slot_t                    tail;
    slot_t                    free_head;
    int unsigned              count;
    rsp_t                     expected_rsps [$];
    int unsigned              errors;
    int unsigned              checked;
    int unsigned              op_seen [4];
    int unsigned              bad_seen;
    int unsigned              full_seen;

    function new();
        for (int i = 0; i < CAPACITY; i++)
            next_mem[i] = slot_t'(i + 1);
        head      = '0;
        tail      = '0;
        free_head = '0;
        count     = 0;
        errors    = 0;
        checked   = 0;
        bad_seen  = 0;
        full_seen = 0;
        foreach (op_seen[i])
            op_seen[i] = 0;
    endfunction

    function slot_t follow_links(int unsigned steps);
        slot_t s;
        s = head;
        for (int unsigned i = 0; i < steps; i++)
            s = next_mem[s];
        return s;
    endfunction

    function void release_slot(slot_t s);
        next_mem[s] = free_head;
        free_head   = s;
    endfunction

    function rsp_t predict_response(req_t r);
        rsp_t  o;
        slot_t s;
        slot_t prev;
        o.status     = ST_OK;
        o.read_value = '0;
        op_seen[r.opcode]++;
        if (r.opcode == OP_READ || r.opcode == OP_REMOVE) begin
            if (r.index >= count) begin
                o.status = ST_BAD_INDEX;
                if (r.opcode == OP_READ)
                    o.read_value = -1;
            end else if (r.opcode == OP_READ) begin
                o.read_value = word_mem[follow_links(r.index)];
            end else if (r.index == 0) begin
                s    = head;
                head = next_mem[s];
                if (count == 1)
                    tail = '0;
                release_slot(s);
                count--;
            end else begin
                prev           = follow_links(r.index - 1);
                s              = next_mem[prev];
                next_mem[prev] = next_mem[s];
                if (r.index == count - 1)
                    tail = prev;
                release_slot(s);
                count--;
            end
        end else if (count >= CAPACITY) begin
            o.status = ST_FULL;
        end else begin
            s           = free_head;
            free_head   = next_mem[s];
            word_mem[s] = r.value;
            if (r.opcode == OP_INS_HEAD) begin
                next_mem[s] = head;
                head        = s;
                if (count == 0)
                    tail = s;
            end else if (count == 0) begin
                head = s;
                tail = s;
            end else begin
                next_mem[tail] = s;
                tail           = s;
            end
            count++;
        end
        if (o.status == ST_BAD_INDEX)
            bad_seen++;
        if (o.status == ST_FULL)
            full_seen++;
        o.list_count = count[6:0];
        return o;
    endfunction

    function void note_request(req_t r);
        expected_rsps.insert(expected_rsps.size(), predict_response(r));
    endfunction

    function void check_response(rsp_t got);
        rsp_t want;
        if (expected_rsps.size() == 0) begin
            $display("%0t ERROR response with none outstanding: status %0d value %0d count %0d",
                     $time, got.status, got.read_value, got.list_count);
            errors++;
            return;
        end
        want = expected_rsps.pop_front();
        checked++;
        if (got.status !== want.status) begin
            $display("%0t ERROR status: expected %0d, actual %0d",
                     $time, want.status, got.status);
            errors++;
        end
        if (got.read_value !== want.read_value) begin
            $display("%0t ERROR read_value: expected %0d, actual %0d",
                     $time, want.read_value, got.read_value);
            errors++;
        end
        if (got.list_count !== want.list_count) begin
            $display("%0t ERROR list_count: expected %0d, actual %0d",
                     $time, want.list_count, got.list_count);
            errors++;
        end
    endfunction
endclass

module tb;

    // Random traffic runs in phases, each biased towards growing, shrinking or churning the list.
    typedef enum int {
        PH_FILL,
        PH_DRAIN,
        PH_MIX
    } phase_e;

    localparam int RANDOM_REQUESTS = 1650;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    // When set, neither side idles, so requests and responses run back to back.
    bit          quiet_mode = 1'b0;
    int unsigned rsp_hold   = 0;
    int unsigned sent       = 0;

    list_scoreboard board = new();

    indexed_linked_list_engine DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int unsigned draw_gap();
        if (quiet_mode)
            return 0;
        return $urandom_range(0, 6);
    endfunction

    // Present one request, holding it steady until the engine takes it. The valid line is
    // only dropped when an idle gap is wanted, so back-to-back requests keep it high.
    task automatic send_request(input req_t item);
        int unsigned gap;
        gap = draw_gap();
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        board.note_request(item);
        sent++;
    endtask

    task automatic send_fields(input op_t op, input logic [15:0] idx, input logic [31:0] val);
        req_t item;
        item.opcode = op;
        item.index  = idx;
        item.value  = val;
        send_request(item);
    endtask

    // Most indices land inside the list, with the ends favoured; the rest are mostly out of range,
    // from just past the end up to the largest index the field can carry.
    function automatic logic [15:0] pick_index(int unsigned live);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (live != 0 && roll < 88)
        begin
            case ($urandom_range(0, 3))
                0:       return 16'd0;
                1:       return 16'(live - 1);
                default: return 16'($urandom_range(0, live - 1));
            endcase
        end
        case (roll % 4)
            0:       return 16'(live);
            1:       return 16'(live + $urandom_range(1, 8));
            2:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 19))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic op_t pick_opcode(phase_e phase);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        case (phase)
            PH_FILL:
                if (roll < 85)
                    return (roll % 2 == 0) ? OP_INS_HEAD : OP_INS_TAIL;
                else if (roll < 95)
                    return OP_READ;
                else
                    return OP_REMOVE;
            PH_DRAIN:
                if (roll < 75)
                    return OP_REMOVE;
                else if (roll < 90)
                    return OP_READ;
                else
                    return (roll % 2 == 0) ? OP_INS_HEAD : OP_INS_TAIL;
            default:
                return op_t'(roll % 4);
        endcase
    endfunction

    // The response side draws a fresh stall, possibly empty, after every response it accepts.
    // Ready is held low for the drawn stall whether or not the next response has yet appeared.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                rsp_hold = draw_gap();
                if (rsp_hold != 0)
                    rsp_ready <= 1'b0;
            end
            else if (!rsp_ready)
            begin
                if (rsp_hold > 1)
                    rsp_hold--;
                else
                begin
                    rsp_hold = 0;
                    rsp_ready <= 1'b1;
                end
            end
        end
    end

    // Every response the engine hands over is compared against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            board.check_response(rsp);
    end

    initial
    begin
        phase_e      phase;
        int unsigned phase_len;
        int unsigned random_sent;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed opening: requests against the empty list, inserts of the extreme words at
        // both ends, reads at the ends and just past them, removal of the tail followed by a
        // tail insert, removal from the middle, and emptying the list before refilling it.
        send_fields(OP_READ,     16'd0,     32'd0);
        send_fields(OP_REMOVE,   16'd0,     32'd0);
        send_fields(OP_READ,     16'hFFFF,  32'hFFFF_FFFF);
        send_fields(OP_INS_TAIL, 16'd0,     32'h7FFF_FFFF);
        send_fields(OP_INS_HEAD, 16'hFFFF,  32'h8000_0000);
        send_fields(OP_INS_HEAD, 16'd0,     32'hFFFF_FFFF);
        send_fields(OP_INS_TAIL, 16'h5A5A,  32'h0000_0000);
        send_fields(OP_INS_TAIL, 16'd0,     32'h5555_AAAA);
        send_fields(OP_READ,     16'd0,     32'd0);
        send_fields(OP_READ,     16'd2,     32'd0);
        send_fields(OP_READ,     16'd4,     32'd0);
        send_fields(OP_READ,     16'd5,     32'd0);
        send_fields(OP_READ,     16'hFFFF,  32'd0);
        send_fields(OP_REMOVE,   16'd4,     32'd0);
        send_fields(OP_INS_TAIL, 16'd0,     32'h0000_1234);
        send_fields(OP_REMOVE,   16'd0,     32'd0);
        send_fields(OP_REMOVE,   16'd2,     32'd0);
        send_fields(OP_READ,     16'd1,     32'd0);
        send_fields(OP_REMOVE,   16'hFFFF,  32'd0);
        send_fields(OP_REMOVE,   16'd0,     32'd0);
        send_fields(OP_REMOVE,   16'd0,     32'd0);
        send_fields(OP_REMOVE,   16'd0,     32'd0);
        send_fields(OP_INS_HEAD, 16'd0,     32'd42);
        send_fields(OP_INS_TAIL, 16'd0,     32'd7);
        send_fields(OP_READ,     16'd1,     32'd0);

        // Random part. Fill phases can run long enough to reach a full store and then knock on
        // it; drain phases tend to empty the list again, so both ends of the count are visited often.
        random_sent = 0;
        while (random_sent < RANDOM_REQUESTS)
        begin
            phase      = phase_e'($urandom_range(0, 2));
            phase_len  = $urandom_range(20, 120);
            quiet_mode = ($urandom_range(0, 4) == 0);
            for (int unsigned i = 0; i < phase_len && random_sent < RANDOM_REQUESTS; i++)
            begin
                req_t item;
                item.opcode = pick_opcode(phase);
                item.index  = pick_index(board.count);
                item.value  = pick_value();
                send_request(item);
                random_sent++;
            end
        end
        quiet_mode = 1'b0;

        // Drain: let the outstanding responses arrive, then watch a little longer for strays.
        @(posedge clk);
        req_valid <= 1'b0;
        while (board.expected_rsps.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        $display("Ran %0d requests: %0d reads, %0d head inserts, %0d tail inserts, %0d removes.",
                 sent, board.op_seen[OP_READ], board.op_seen[OP_INS_HEAD],
                 board.op_seen[OP_INS_TAIL], board.op_seen[OP_REMOVE]);
        $display("Checked %0d responses, of which %0d bad index and %0d store full.",
                 board.checked, board.bad_seen, board.full_seen);
        if (board.errors == 0 && board.expected_rsps.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of every request walking a full list.
    initial
    begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> sim.f
rtl/ille_pkg.sv
rtl/ille_ram.sv
rtl/ille_link_mem.sv
rtl/indexed_linked_list_engine.sv
rtl/ille_checker.sv
test/tb.sv
